@@ src/qsalu_pkg.sv @@
`timescale 1ns / 1ps

package qsalu_pkg;

    typedef struct packed
    {
        logic [3:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } qsalu_in_t;

    typedef struct packed
    {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               saturated;
        logic               divide_by_zero;
    } qsalu_out_t;

    // sideband that travels with each transaction through the divider stages
    typedef struct packed
    {
        logic [3:0]         command;
        logic signed [31:0] result;
        logic               cmp;
        logic               sat;
        logic               dz;
        logic               q_neg;
        logic signed [63:0] prod;
    } qsalu_side_t;

    typedef struct packed
    {
        logic signed [31:0] value;
        logic               sat;
    } qsalu_rs_t;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_SUB      = 4'd1;
    localparam logic [3:0] CMD_MUL      = 4'd2;
    localparam logic [3:0] CMD_DIV      = 4'd3;
    localparam logic [3:0] CMD_GT       = 4'd4;
    localparam logic [3:0] CMD_LT       = 4'd5;
    localparam logic [3:0] CMD_GE       = 4'd6;
    localparam logic [3:0] CMD_LE       = 4'd7;
    localparam logic [3:0] CMD_EQ       = 4'd8;
    localparam logic [3:0] CMD_NE       = 4'd9;
    localparam logic [3:0] CMD_MIN      = 4'd10;
    localparam logic [3:0] CMD_MAX      = 4'd11;
    localparam logic [3:0] CMD_INC      = 4'd12;
    localparam logic [3:0] CMD_DEC      = 4'd13;
    localparam logic [3:0] CMD_TO_INT   = 4'd14;
    localparam logic [3:0] CMD_FROM_INT = 4'd15;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    function automatic qsalu_rs_t clamp33(input logic [32:0] v);
        qsalu_rs_t r;
        if (v[32] != v[31])
        begin
            r.value = v[32] ? WORD_MIN : WORD_MAX;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = v[31:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ src/qsalu_prep.sv @@
`timescale 1ns / 1ps

module qsalu_prep #(
    parameter int FRAC_BITS = 8,
    parameter int DW        = 40,
    parameter int ACC_W     = 72
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  qsalu_pkg::qsalu_in_t  in_data,
    output logic                  valid,
    output qsalu_pkg::qsalu_side_t side,
    output logic [ACC_W-1:0]      acc,
    output logic [31:0]           divisor
);
    import qsalu_pkg::*;

    logic               valid_reg;
    qsalu_side_t        side_reg, side_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [31:0]        dvs_reg, dvs_next;

    logic signed [31:0] a, b;
    logic [31:0]        b_u;
    logic signed [DW:0] t_base, half_x, t_adj, t_mag;
    logic signed [DW-1:0] fi;
    qsalu_rs_t          rs_add, rs_sub, rs_inc, rs_dec;

    always_comb
    begin
        a      = in_data.operand_a;
        b      = in_data.operand_b;
        b_u    = b;
        rs_add = clamp33({a[31], a} + {b[31], b});
        rs_sub = clamp33({a[31], a} - {b[31], b});
        rs_inc = clamp33({a[31], a} + 33'd1);
        rs_dec = clamp33({a[31], a} - 33'd1);
        fi     = {a, {FRAC_BITS{1'b0}}};

        t_base = {a[31], a, {FRAC_BITS{1'b0}}};
        half_x = {{(DW - 30){b[31]}}, b[31:1]};
        t_adj  = (a[31] == b[31]) ? (t_base + half_x) : (t_base - half_x);
        t_mag  = t_adj[DW] ? -t_adj : t_adj;
        dvs_next = b[31] ? (~b_u + 32'd1) : b_u;
        acc_next = {32'd0, t_mag[DW-1:0]};

        side_next.command = in_data.command;
        side_next.result  = '0;
        side_next.cmp     = 1'b0;
        side_next.sat     = 1'b0;
        side_next.dz      = 1'b0;
        side_next.q_neg   = a[31] ^ b[31];
        side_next.prod    = a * b;

        unique case (in_data.command)
            CMD_ADD:
            begin
                side_next.result = rs_add.value;
                side_next.sat    = rs_add.sat;
            end
            CMD_SUB:
            begin
                side_next.result = rs_sub.value;
                side_next.sat    = rs_sub.sat;
            end
            CMD_DIV:
            begin
                if (b == 32'sd0)
                begin
                    side_next.dz     = 1'b1;
                    side_next.sat    = 1'b1;
                    side_next.result = a[31] ? WORD_MIN : WORD_MAX;
                end
            end
            CMD_GT:  side_next.cmp = a > b;
            CMD_LT:  side_next.cmp = a < b;
            CMD_GE:  side_next.cmp = a >= b;
            CMD_LE:  side_next.cmp = a <= b;
            CMD_EQ:  side_next.cmp = a == b;
            CMD_NE:  side_next.cmp = a != b;
            CMD_MIN: side_next.result = (a < b) ? a : b;
            CMD_MAX: side_next.result = (a > b) ? a : b;
            CMD_INC:
            begin
                side_next.result = rs_inc.value;
                side_next.sat    = rs_inc.sat;
            end
            CMD_DEC:
            begin
                side_next.result = rs_dec.value;
                side_next.sat    = rs_dec.sat;
            end
            CMD_TO_INT: side_next.result = a >>> FRAC_BITS;
            CMD_FROM_INT:
            begin
                if (fi[DW-1:31] != {(FRAC_BITS + 1){fi[DW-1]}})
                begin
                    side_next.result = a[31] ? WORD_MIN : WORD_MAX;
                    side_next.sat    = 1'b1;
                end
                else
                begin
                    side_next.result = fi[31:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            acc_reg  <= acc_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign valid   = valid_reg;
    assign side    = side_reg;
    assign acc     = acc_reg;
    assign divisor = dvs_reg;

endmodule

@@ src/qsalu_div_pipe.sv @@
`timescale 1ns / 1ps

module qsalu_div_pipe #(
    parameter int DW    = 40,
    parameter int ACC_W = 72
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  qsalu_pkg::qsalu_side_t in_side,
    input  logic [ACC_W-1:0]       in_acc,
    input  logic [31:0]            in_divisor,
    output logic                   valid,
    output qsalu_pkg::qsalu_side_t side,
    output logic [DW-1:0]          quotient
);
    import qsalu_pkg::*;

    logic [DW-1:0]    valid_reg;
    qsalu_side_t      side_reg [DW];
    logic [ACC_W-1:0] acc_reg  [DW];
    logic [31:0]      dvs_reg  [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_step
            logic             src_valid;
            qsalu_side_t      src_side;
            logic [ACC_W-1:0] src_acc;
            logic [31:0]      src_dvs;
            logic [32:0]      top;
            logic             qbit;
            logic [32:0]      diff;
            logic [ACC_W-1:0] acc_next;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_side  = in_side;
                assign src_acc   = in_acc;
                assign src_dvs   = in_divisor;
            end
            else
            begin : g_rest
                assign src_valid = valid_reg[k-1];
                assign src_side  = side_reg[k-1];
                assign src_acc   = acc_reg[k-1];
                assign src_dvs   = dvs_reg[k-1];
            end

            // one restoring step: shift in next dividend bit, trial subtract
            always_comb
            begin
                top      = src_acc[ACC_W-1:DW-1];
                diff     = top - {1'b0, src_dvs};
                qbit     = (top >= {1'b0, src_dvs});
                acc_next = {(qbit ? diff[31:0] : top[31:0]), src_acc[DW-2:0], qbit};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= src_side;
                    acc_reg[k]  <= acc_next;
                    dvs_reg[k]  <= src_dvs;
                end
            end
        end
    endgenerate

    assign valid    = valid_reg[DW-1];
    assign side     = side_reg[DW-1];
    assign quotient = acc_reg[DW-1][DW-1:0];

endmodule

@@ src/qsalu_post.sv @@
`timescale 1ns / 1ps

module qsalu_post #(
    parameter int FRAC_BITS = 8,
    parameter int DW        = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  qsalu_pkg::qsalu_side_t in_side,
    input  logic [DW-1:0]          quotient,
    output logic                   valid,
    output qsalu_pkg::qsalu_out_t  data
);
    import qsalu_pkg::*;

    localparam logic [DW-1:0] Q_LIM = {{(DW - 32){1'b0}}, 1'b1, 31'd0};

    logic               valid_reg;
    qsalu_out_t         data_reg, data_next;
    logic signed [63:0] m_round, m_shift;
    logic [31:0]        q_low;

    always_comb
    begin
        m_round = in_side.prod + (64'sd1 <<< (FRAC_BITS - 1));
        m_shift = m_round >>> FRAC_BITS;
        q_low   = quotient[31:0];

        data_next.result_value   = in_side.result;
        data_next.compare_true   = in_side.cmp;
        data_next.saturated      = in_side.sat;
        data_next.divide_by_zero = in_side.dz;

        if (in_side.command == CMD_MUL)
        begin
            if (m_shift[63:31] != {33{m_shift[63]}})
            begin
                data_next.result_value = m_shift[63] ? WORD_MIN : WORD_MAX;
                data_next.saturated    = 1'b1;
            end
            else
            begin
                data_next.result_value = m_shift[31:0];
            end
        end
        else if ((in_side.command == CMD_DIV) && !in_side.dz)
        begin
            if (in_side.q_neg)
            begin
                if (quotient > Q_LIM)
                begin
                    data_next.result_value = WORD_MIN;
                    data_next.saturated    = 1'b1;
                end
                else
                begin
                    data_next.result_value = ~q_low + 32'd1;
                end
            end
            else
            begin
                if (quotient >= Q_LIM)
                begin
                    data_next.result_value = WORD_MAX;
                    data_next.saturated    = 1'b1;
                end
                else
                begin
                    data_next.result_value = q_low;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ src/q_format_saturating_alu.sv @@
`timescale 1ns / 1ps
// channel | signals                        | direction | transaction
// cmd     | cmd_valid cmd_ready cmd_data   | in        | command, operand_a, operand_b
// rsp     | rsp_valid rsp_ready rsp_data   | out       | result_value, flags
// one transaction enters per cycle unless the pipeline stalls, results leave in order
// pipeline stages: prep stage, 32 + FRAC_BITS divider steps, output stage
// the pipeline length is set by the restoring divider, one quotient bit per stage
// rst_n clears only the valid bits of every stage
// when rsp is full and not taken, all stages hold and cmd_ready is low

module q_format_saturating_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  qsalu_pkg::qsalu_in_t  cmd_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output qsalu_pkg::qsalu_out_t rsp_data
);
    import qsalu_pkg::*;

    localparam int DW    = 32 + FRAC_BITS;
    localparam int ACC_W = 32 + DW;

    logic             en;
    logic             p_valid, d_valid;
    qsalu_side_t      p_side, d_side;
    logic [ACC_W-1:0] p_acc;
    logic [31:0]      p_dvs;
    logic [DW-1:0]    d_quot;

    assign en        = !rsp_valid || rsp_ready;
    assign cmd_ready = en;

    qsalu_prep #(.FRAC_BITS(FRAC_BITS), .DW(DW), .ACC_W(ACC_W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cmd_valid),
        .in_data  (cmd_data),
        .valid    (p_valid),
        .side     (p_side),
        .acc      (p_acc),
        .divisor  (p_dvs)
    );

    qsalu_div_pipe #(.DW(DW), .ACC_W(ACC_W)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (p_valid),
        .in_side    (p_side),
        .in_acc     (p_acc),
        .in_divisor (p_dvs),
        .valid      (d_valid),
        .side       (d_side),
        .quotient   (d_quot)
    );

    qsalu_post #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid),
        .in_side  (d_side),
        .quotient (d_quot),
        .valid    (rsp_valid),
        .data     (rsp_data)
    );

    a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.divide_by_zero |-> rsp_data.saturated)
        else $error("divide by zero without saturation");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.compare_true |-> rsp_data.result_value == 32'sd0)
        else $error("comparison with nonzero result");

    a_cmp_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.compare_true |-> !rsp_data.saturated)
        else $error("comparison flagged saturated");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(p_valid) && $stable(d_valid))
        else $error("pipeline moved during stall");

endmodule
